>>> design/rcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared widths, codes and types of the region change detector.
// ----------------------------------------------------------------------------
package rcd_pkg;

    // Reference store and sampling grid
    localparam int REF_DEPTH = 4096;
    localparam int REF_AW    = $clog2(REF_DEPTH);
    localparam int STEP_X    = 1;
    localparam int STEP_Y    = 1;

    // Field widths
    localparam int COORD_W    = 12;
    localparam int CHAN_W     = 8;
    localparam int INT_W      = 10;
    localparam int TOL_W      = 10;
    localparam int PCT_W      = 8;
    localparam int CNT_W      = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    // Offset arithmetic: row times width plus column
    localparam int PROD_W = 2 * COORD_W;
    localparam int OFF_W  = PROD_W + 1;

    // Grid test by reciprocal multiplication, exact for 12-bit values and steps up to 16
    localparam int GRID_SHIFT   = 18;
    localparam int RECIP_W      = GRID_SHIFT + 1;
    localparam int QPROD_W      = COORD_W + RECIP_W;
    localparam int GRID_RECIP_X = (1 << GRID_SHIFT) / STEP_X + 1;
    localparam int GRID_RECIP_Y = (1 << GRID_SHIFT) / STEP_Y + 1;

    // Judgement arithmetic
    localparam int PCT_SCALE = 100;
    localparam int PROD_A_W  = CNT_W + 7;
    localparam int PROD_B_W  = PCT_W + 1 + CNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Operation codes
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_COMPARE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_BELOW = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_ABOVE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERCENT   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR     = 4'd7;

    // Configuration as seen by front and back
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [TOL_W-1:0]   tol_below;
        logic [TOL_W-1:0]   tol_above;
        logic [PCT_W-1:0]   percent;
        logic               color_mode;
    } rcd_cfg_t;

    // Register values after reset: all zero but color mode
    localparam rcd_cfg_t CFG_RESET = '{
        left: '0, top: '0, right: '0, bottom: '0,
        tol_below: '0, tol_above: '0, percent: '0, color_mode: 1'b1
    };

    // Classified pixel handed from front to back
    typedef struct packed {
        logic              op;
        logic              last;
        logic              sampled;
        logic [REF_AW-1:0] idx;
        logic [INT_W-1:0]  cur;
    } rcd_item_t;

endpackage

>>> design/rcd_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_pixel_if
// Pixel request channel: operation, coordinates, color and frame end.
// ----------------------------------------------------------------------------
interface rcd_pixel_if;
    import rcd_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  pixel_red;
    logic [CHAN_W-1:0]  pixel_green;
    logic [CHAN_W-1:0]  pixel_blue;
    logic               frame_end;

    modport source (
        output valid, operation, pixel_x, pixel_y, pixel_red, pixel_green,
               pixel_blue, frame_end,
        input  ready
    );

    modport sink (
        input  valid, operation, pixel_x, pixel_y, pixel_red, pixel_green,
               pixel_blue, frame_end,
        output ready
    );
endinterface

>>> design/rcd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_result_if
// Result channel: region verdict and the counts behind it.
// ----------------------------------------------------------------------------
interface rcd_result_if;
    import rcd_pkg::*;

    logic             valid;
    logic             ready;
    logic             region_same;
    logic [CNT_W-1:0] changed_count;
    logic [CNT_W-1:0] sampled_count;
    logic             empty_region;

    modport source (
        output valid, region_same, changed_count, sampled_count, empty_region,
        input  ready
    );

    modport sink (
        input  valid, region_same, changed_count, sampled_count, empty_region,
        output ready
    );
endinterface

>>> design/rcd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rcd_cfg_if;
    import rcd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> design/rcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_front
// Accepts pixels, tests rectangle and grid, forms store offset and intensity.
// ----------------------------------------------------------------------------
module rcd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  rcd_pkg::rcd_cfg_t  cfg,
    rcd_pixel_if.sink          pixels,
    output rcd_pkg::rcd_item_t push_item,
    output logic               push,
    input  logic               q_full
);
    import rcd_pkg::*;

    logic front_en;
    logic accept;

    // Stage 1: rectangle test, relative position, intensity
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_op_reg, s1_last_reg, s1_inside_reg;
    logic [COORD_W-1:0] s1_dx_reg, s1_dy_reg, s1_w_reg;
    logic [INT_W-1:0]   s1_cur_reg;
    logic               s1_inside_next;
    logic [COORD_W-1:0] s1_dx_next, s1_dy_next, s1_w_next;
    logic [INT_W-1:0]   s1_cur_next;

    // Stage 2: grid quotients and row offset product
    logic               s2_valid_reg, s2_valid_next;
    logic               s2_op_reg, s2_last_reg, s2_inside_reg;
    logic [COORD_W-1:0] s2_dx_reg, s2_dy_reg, s2_qx_reg, s2_qy_reg;
    logic [PROD_W-1:0]  s2_prod_reg;
    logic [INT_W-1:0]   s2_cur_reg;
    logic [QPROD_W-1:0] qx_prod, qy_prod;
    logic [PROD_W-1:0]  s2_prod_next;

    // Push stage: grid check and store bound
    logic [PROD_W-1:0] grid_x, grid_y;
    logic [OFF_W-1:0]  offset;
    logic              on_grid, in_store;

    // Stall the whole front only when its last stage cannot push
    assign front_en     = !s2_valid_reg || !q_full;
    assign pixels.ready = front_en;
    assign accept       = pixels.valid && front_en;

    // Classify the incoming pixel
    assign s1_inside_next = (pixels.pixel_x >= cfg.left) && (pixels.pixel_x < cfg.right) &&
                            (pixels.pixel_y >= cfg.top) && (pixels.pixel_y < cfg.bottom);
    assign s1_dx_next     = pixels.pixel_x - cfg.left;
    assign s1_dy_next     = pixels.pixel_y - cfg.top;
    assign s1_w_next      = cfg.right - cfg.left;
    assign s1_cur_next    = cfg.color_mode
                          ? INT_W'(pixels.pixel_red) + INT_W'(pixels.pixel_green)
                            + INT_W'(pixels.pixel_blue)
                          : INT_W'(pixels.pixel_red);
    assign s1_valid_next  = front_en ? accept : s1_valid_reg;

    // Quotients by the grid steps and row times width
    assign qx_prod       = QPROD_W'(s1_dx_reg) * QPROD_W'(GRID_RECIP_X);
    assign qy_prod       = QPROD_W'(s1_dy_reg) * QPROD_W'(GRID_RECIP_Y);
    assign s2_prod_next  = PROD_W'(s1_dy_reg) * PROD_W'(s1_w_reg);
    assign s2_valid_next = front_en ? s1_valid_reg : s2_valid_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            s1_op_reg     <= pixels.operation;
            s1_last_reg   <= pixels.frame_end;
            s1_inside_reg <= s1_inside_next;
            s1_dx_reg     <= s1_dx_next;
            s1_dy_reg     <= s1_dy_next;
            s1_w_reg      <= s1_w_next;
            s1_cur_reg    <= s1_cur_next;

            s2_op_reg     <= s1_op_reg;
            s2_last_reg   <= s1_last_reg;
            s2_inside_reg <= s1_inside_reg;
            s2_dx_reg     <= s1_dx_reg;
            s2_dy_reg     <= s1_dy_reg;
            s2_qx_reg     <= qx_prod[GRID_SHIFT +: COORD_W];
            s2_qy_reg     <= qy_prod[GRID_SHIFT +: COORD_W];
            s2_prod_reg   <= s2_prod_next;
            s2_cur_reg    <= s1_cur_reg;
        end
    end

    // On the grid when the quotient times the step gives back the distance
    assign grid_x   = PROD_W'(s2_qx_reg) * PROD_W'(STEP_X);
    assign grid_y   = PROD_W'(s2_qy_reg) * PROD_W'(STEP_Y);
    assign on_grid  = (grid_x == PROD_W'(s2_dx_reg)) && (grid_y == PROD_W'(s2_dy_reg));
    assign offset   = OFF_W'(s2_prod_reg) + OFF_W'(s2_dx_reg);
    assign in_store = offset < OFF_W'(REF_DEPTH);

    // Hand the classified pixel to the queue
    assign push              = s2_valid_reg && !q_full;
    assign push_item.op      = s2_op_reg;
    assign push_item.last    = s2_last_reg;
    assign push_item.sampled = s2_inside_reg && on_grid && in_store;
    assign push_item.idx     = offset[REF_AW-1:0];
    assign push_item.cur     = s2_cur_reg;

endmodule

>>> design/rcd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_queue
// Short queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module rcd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rcd_pkg::rcd_item_t push_item,
    input  logic               pop,
    output rcd_pkg::rcd_item_t head_item,
    output logic               full,
    output logic               empty
);
    import rcd_pkg::*;

    rcd_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/rcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_back
// Reference store access, tolerance check, counters and frame verdict.
// ----------------------------------------------------------------------------
module rcd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rcd_pkg::rcd_cfg_t  cfg,
    input  rcd_pkg::rcd_item_t head_item,
    input  logic               q_empty,
    output logic               pop,
    rcd_result_if.source       results
);
    import rcd_pkg::*;

    logic back_en;

    // Reference store
    logic [INT_W-1:0] ref_mem [REF_DEPTH];
    logic [INT_W-1:0] ref_rdata_reg;
    logic             wr_en, rd_en;

    // Compare stage
    logic             b2_valid_reg, b2_valid_next;
    logic             b2_op_reg, b2_last_reg, b2_sampled_reg;
    logic [INT_W-1:0] b2_cur_reg;
    logic [INT_W:0]   cur_lo, ref_hi;
    logic             changed, counted;

    // Frame counters
    logic [CNT_W-1:0] smp_cnt_reg, smp_cnt_next;
    logic [CNT_W-1:0] chg_cnt_reg, chg_cnt_next;
    logic [CNT_W-1:0] smp_upd, chg_upd;

    // Verdict stages
    logic                r1_valid_reg, r1_valid_next;
    logic [CNT_W-1:0]    r1_chg_reg, r1_smp_reg;
    logic                r2_valid_reg, r2_valid_next;
    logic [CNT_W-1:0]    r2_chg_reg, r2_smp_reg;
    logic [PROD_A_W-1:0] r2_prod_a_reg, prod_a_next;
    logic [PROD_B_W-1:0] r2_prod_b_reg, prod_b_next;
    logic [PCT_W:0]      pct_plus;
    logic                out_valid_reg, out_valid_next;
    logic                out_same_reg, out_empty_reg;
    logic [CNT_W-1:0]    out_chg_reg, out_smp_reg;
    logic                same_next, empty_next;

    // Stall the back only while a result waits to be taken
    assign back_en = !out_valid_reg || results.ready;
    assign pop     = back_en && !q_empty;
    assign wr_en   = pop && head_item.sampled && (head_item.op == OP_CAPTURE);
    assign rd_en   = pop && head_item.sampled && (head_item.op == OP_COMPARE);

    // Write captures, read for compares
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ref_mem[head_item.idx] <= head_item.cur;
        end
        if (rd_en)
        begin
            ref_rdata_reg <= ref_mem[head_item.idx];
        end
    end

    // Check the tolerance band: cur < ref - below or cur > ref + above
    assign cur_lo  = {1'b0, b2_cur_reg} + {1'b0, cfg.tol_below};
    assign ref_hi  = {1'b0, ref_rdata_reg} + {1'b0, cfg.tol_above};
    assign changed = (cur_lo < {1'b0, ref_rdata_reg}) || ({1'b0, b2_cur_reg} > ref_hi);
    assign counted = b2_valid_reg && (b2_op_reg == OP_COMPARE) && b2_sampled_reg;

    // Saturating counts including the current pixel
    always_comb
    begin
        smp_upd = smp_cnt_reg;
        chg_upd = chg_cnt_reg;
        if (counted)
        begin
            if (smp_cnt_reg != CNT_MAX)
            begin
                smp_upd = smp_cnt_reg + 1'b1;
            end
            if (changed && (chg_cnt_reg != CNT_MAX))
            begin
                chg_upd = chg_cnt_reg + 1'b1;
            end
        end
    end

    // Clear counters at every frame end
    always_comb
    begin
        smp_cnt_next = smp_cnt_reg;
        chg_cnt_next = chg_cnt_reg;
        if (back_en && b2_valid_reg)
        begin
            if (b2_last_reg)
            begin
                smp_cnt_next = '0;
                chg_cnt_next = '0;
            end
            else
            begin
                smp_cnt_next = smp_upd;
                chg_cnt_next = chg_upd;
            end
        end
    end

    assign b2_valid_next  = back_en ? pop : b2_valid_reg;
    assign r1_valid_next  = back_en ? (b2_valid_reg && b2_last_reg && (b2_op_reg == OP_COMPARE))
                                    : r1_valid_reg;
    assign r2_valid_next  = back_en ? r1_valid_reg : r2_valid_reg;
    assign out_valid_next = back_en ? r2_valid_reg : out_valid_reg;

    // Percent test without division: floor(c*100/s) <= p  <=>  c*100 < (p+1)*s
    assign pct_plus    = {1'b0, cfg.percent} + 1'b1;
    assign prod_a_next = PROD_A_W'(r1_chg_reg) * PROD_A_W'(PCT_SCALE);
    assign prod_b_next = PROD_B_W'(pct_plus) * PROD_B_W'(r1_smp_reg);
    assign empty_next  = r2_smp_reg == '0;

    always_comb
    begin
        if (empty_next)
        begin
            same_next = 1'b1;
        end
        else if (cfg.percent != '0)
        begin
            same_next = PROD_B_W'(r2_prod_a_reg) < r2_prod_b_reg;
        end
        else
        begin
            same_next = r2_chg_reg == '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg  <= 1'b0;
            r1_valid_reg  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            smp_cnt_reg   <= '0;
            chg_cnt_reg   <= '0;
        end
        else
        begin
            b2_valid_reg  <= b2_valid_next;
            r1_valid_reg  <= r1_valid_next;
            r2_valid_reg  <= r2_valid_next;
            out_valid_reg <= out_valid_next;
            smp_cnt_reg   <= smp_cnt_next;
            chg_cnt_reg   <= chg_cnt_next;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            b2_op_reg      <= head_item.op;
            b2_last_reg    <= head_item.last;
            b2_sampled_reg <= head_item.sampled;
            b2_cur_reg     <= head_item.cur;

            r1_chg_reg     <= chg_upd;
            r1_smp_reg     <= smp_upd;

            r2_chg_reg     <= r1_chg_reg;
            r2_smp_reg     <= r1_smp_reg;
            r2_prod_a_reg  <= prod_a_next;
            r2_prod_b_reg  <= prod_b_next;

            out_chg_reg    <= r2_chg_reg;
            out_smp_reg    <= r2_smp_reg;
            out_same_reg   <= same_next;
            out_empty_reg  <= empty_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.region_same   = out_same_reg;
    assign results.changed_count = out_chg_reg;
    assign results.sampled_count = out_smp_reg;
    assign results.empty_region  = out_empty_reg;

endmodule

>>> design/region_change_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_change_detector_unit
// Frame difference change detector over a watched rectangle.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  pixels    in         operation, pixel_x, pixel_y, pixel_red/green/blue, frame_end
//  results   out        region_same, changed_count, sampled_count, empty_region
//  cfg       in         index, data (register writes, always ready)
//
//  One pixel request per clock is accepted sustained while the queue is not
//  full; the reference store has one port and every pixel touches it at most once.
//  A verdict passes r1, r2 and the output register after the frame_end compare.
//  Reset clears the counters and all valid bits; the store holds no reset value.
//  A stalled result holds the back end; the four-entry queue then fills and
//  pixels stop being taken after the front pipeline backs up.
// ----------------------------------------------------------------------------
module region_change_detector_unit (
    input  logic clk,
    input  logic rst_n,
    rcd_pixel_if.sink    pixels,
    rcd_result_if.source results,
    rcd_cfg_if.sink      cfg
);
    import rcd_pkg::*;

    rcd_cfg_t  cfg_reg, cfg_next;
    rcd_item_t push_item, head_item;
    logic      push, pop, q_full, q_empty;

    // Register writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_LEFT:      cfg_next.left       = cfg.data[COORD_W-1:0];
                REG_TOP:       cfg_next.top        = cfg.data[COORD_W-1:0];
                REG_RIGHT:     cfg_next.right      = cfg.data[COORD_W-1:0];
                REG_BOTTOM:    cfg_next.bottom     = cfg.data[COORD_W-1:0];
                REG_TOL_BELOW: cfg_next.tol_below  = cfg.data[TOL_W-1:0];
                REG_TOL_ABOVE: cfg_next.tol_above  = cfg.data[TOL_W-1:0];
                REG_PERCENT:   cfg_next.percent    = cfg.data[PCT_W-1:0];
                REG_COLOR:     cfg_next.color_mode = cfg.data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify pixels
    rcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pixels    (pixels),
        .push_item (push_item),
        .push      (push),
        .q_full    (q_full)
    );

    // Decouple front and back
    rcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Compare, count, judge
    rcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head_item (head_item),
        .q_empty   (q_empty),
        .pop       (pop),
        .results   (results)
    );

endmodule

>>> design/rcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks on the verdicts of the region change detector.
// ----------------------------------------------------------------------------
module rcd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      out_same,
    input logic [rcd_pkg::CNT_W-1:0] out_changed,
    input logic [rcd_pkg::CNT_W-1:0] out_sampled,
    input logic                      out_empty
);
    import rcd_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_same) &&
        $stable(out_changed) && $stable(out_sampled) && $stable(out_empty))
        else $error("stalled result changed");

    // Flag an empty region exactly when nothing was sampled
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_empty == (out_sampled == '0)))
        else $error("empty flag disagrees with sampled count");

    // Judge an empty region as unchanged
    a_empty_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> out_same)
        else $error("empty region judged changed");

    // Count changed pixels only among sampled ones
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_changed <= out_sampled)
        else $error("changed count exceeds sampled count");

    // Judge a region with no changed pixel as unchanged
    a_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_changed == '0) |-> out_same)
        else $error("region without changes judged changed");

endmodule

bind region_change_detector_unit rcd_checker u_rcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_same    (results.region_same),
    .out_changed (results.changed_count),
    .out_sampled (results.sampled_count),
    .out_empty   (results.empty_region)
);

>>> sim/region_change_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_change_detector_unit_tb
// Drives pixel requests and register writes into the change detector and
// checks every verdict against a cycle-free prediction of the frame counts.
// A short directed pass hits the corner cases; random windows follow, each
// with one capture frame and several compare frames, while both sides of
// the stream stall at random.
// ----------------------------------------------------------------------------
module region_change_detector_unit_tb;
    import rcd_pkg::*;

    localparam int unsigned COORD_MAX     = (1 << COORD_W) - 1;
    localparam int unsigned CHAN_MAX      = (1 << CHAN_W) - 1;
    localparam int unsigned INTENSITY_MAX = 3 * CHAN_MAX;
    localparam int unsigned PCT_MAX       = (1 << PCT_W) - 1;
    localparam int unsigned RANDOM_ITEMS  = 1400;
    localparam int unsigned IDLE_PCT      = 21;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               last;
    } pixel_t;

    typedef struct packed {
        logic             region_same;
        logic [CNT_W-1:0] changed_count;
        logic [CNT_W-1:0] sampled_count;
        logic             empty_region;
    } verdict_t;

    typedef struct {
        int unsigned left;
        int unsigned top;
        int unsigned right;
        int unsigned bottom;
        int unsigned tol_below;
        int unsigned tol_above;
        int unsigned percent;
        int unsigned color;
    } window_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } spot_t;

    // ------------------------------------------------------------------------
    // Predicted reference store, frame counters and verdicts still due
    // ------------------------------------------------------------------------
    class region_verdict_board;
        int unsigned      left, top, right, bottom;
        int unsigned      tol_below, tol_above, percent;
        bit               color_mode;
        logic [INT_W-1:0] reference [REF_DEPTH];
        bit               captured [REF_DEPTH];
        int unsigned      changed_n, sampled_n;
        verdict_t         verdicts_due [$];
        int unsigned      errors, verdicts_checked, empty_seen, moved_seen;

        function new();
            color_mode = 1'b1;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LEFT:      left      = 32'(data);
                REG_TOP:       top       = 32'(data);
                REG_RIGHT:     right     = 32'(data);
                REG_BOTTOM:    bottom    = 32'(data);
                REG_TOL_BELOW: tol_below = 32'(data[TOL_W-1:0]);
                REG_TOL_ABOVE: tol_above = 32'(data[TOL_W-1:0]);
                REG_PERCENT:   percent   = 32'(data[PCT_W-1:0]);
                REG_COLOR:     color_mode = data[0];
                default: ;
            endcase
        endfunction

        // Store offset of a sampled pixel, or -1 when the pixel is not used
        function int locate(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            int unsigned dx, dy, off;
            if (x < left || x >= right || y < top || y >= bottom)
                return -1;
            dx = x - left;
            dy = y - top;
            if ((dx % STEP_X) != 0 || (dy % STEP_Y) != 0)
                return -1;
            off = dy * (right - left) + dx;
            if (off >= REF_DEPTH)
                return -1;
            return int'(off);
        endfunction

        function bit reads_blank(pixel_t p);
            int off;
            off = locate(p.x, p.y);
            return p.op == OP_COMPARE && off >= 0 && !captured[off];
        endfunction

        function verdict_t judge_frame();
            verdict_t v;
            v.changed_count = CNT_W'(changed_n);
            v.sampled_count = CNT_W'(sampled_n);
            v.empty_region  = sampled_n == 0;
            if (v.empty_region)
                v.region_same = 1'b1;
            else if (percent > 0)
                v.region_same = (changed_n * PCT_SCALE) / sampled_n <= percent;
            else
                v.region_same = changed_n == 0;
            return v;
        endfunction

        function void note_pixel(pixel_t p);
            int off;
            int cur, lo, hi;
            off = locate(p.x, p.y);
            cur = color_mode ? int'(p.red) + int'(p.green) + int'(p.blue) : int'(p.red);
            if (off >= 0) begin
                if (p.op == OP_CAPTURE) begin
                    reference[off] = cur[INT_W-1:0];
                    captured[off]  = 1'b1;
                end
                else begin
                    lo = int'(reference[off]) - int'(tol_below);
                    hi = int'(reference[off]) + int'(tol_above);
                    if (sampled_n < CNT_MAX)
                        sampled_n++;
                    if ((cur < lo || cur > hi) && changed_n < CNT_MAX)
                        changed_n++;
                end
            end
            // Close the frame: only a compare request yields a verdict
            if (p.last) begin
                if (p.op == OP_COMPARE)
                    verdicts_due.push_back(judge_frame());
                changed_n = 0;
                sampled_n = 0;
            end
        endfunction

        function void flag(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            errors++;
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: verdict expected none, actual same %0d changed %0d sampled %0d empty %0d",
                         $time, got.region_same, got.changed_count, got.sampled_count,
                         got.empty_region);
                return;
            end
            want = verdicts_due.pop_front();
            verdicts_checked++;
            if (want.empty_region)
                empty_seen++;
            if (!want.region_same)
                moved_seen++;
            if (got.region_same !== want.region_same)
                flag("region_same", CNT_W'(want.region_same), CNT_W'(got.region_same));
            if (got.changed_count !== want.changed_count)
                flag("changed_count", want.changed_count, got.changed_count);
            if (got.sampled_count !== want.sampled_count)
                flag("sampled_count", want.sampled_count, got.sampled_count);
            if (got.empty_region !== want.empty_region)
                flag("empty_region", CNT_W'(want.empty_region), CNT_W'(got.empty_region));
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;

    int unsigned accepted_items;
    int unsigned window_count;
    spot_t       spots [$];

    region_verdict_board board = new();

    rcd_pixel_if  pix ();
    rcd_result_if res ();
    rcd_cfg_if    cfg ();

    region_change_detector_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix),
        .results (res),
        .cfg     (cfg)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold off results at random, except during the calm stretch
    initial
    begin
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            res.ready <= (!calm && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
        end
    end

    // Check each verdict at the falling edge before its handshake edge
    always @(negedge clk)
    begin
        if (rst_n && res.valid === 1'b1 && res.ready === 1'b1)
            board.check_verdict({res.region_same, res.changed_count, res.sampled_count,
                                 res.empty_region});
    end

    // ------------------------------------------------------------------------
    // Request drivers; each is entered right after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_pixel(input pixel_t p);
        logic took;
        // Never compare against an entry that was never captured
        if (board.reads_blank(p))
            p.op = OP_CAPTURE;
        calm = accepted_items >= 600 && accepted_items < 850;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.operation   <= p.op;
        pix.pixel_x     <= p.x;
        pix.pixel_y     <= p.y;
        pix.pixel_red   <= p.red;
        pix.pixel_green <= p.green;
        pix.pixel_blue  <= p.blue;
        pix.frame_end   <= p.last;
        do
        begin
            @(negedge clk);
            took = pix.ready;
            @(posedge clk);
        end
        while (!took);
        accepted_items++;
        board.note_pixel(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        logic took;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[CFG_DATA_W-1:0];
        do
        begin
            @(negedge clk);
            took = cfg.ready;
            @(posedge clk);
        end
        while (!took);
        board.apply_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic program_window(input window_t w);
        write_reg(REG_LEFT, w.left);
        write_reg(REG_TOP, w.top);
        write_reg(REG_RIGHT, w.right);
        write_reg(REG_BOTTOM, w.bottom);
        write_reg(REG_TOL_BELOW, w.tol_below);
        write_reg(REG_TOL_ABOVE, w.tol_above);
        write_reg(REG_PERCENT, w.percent);
        write_reg(REG_COLOR, w.color);
        cfg.valid <= 1'b0;
        window_count++;
    endtask

    // Drop pixel requests, wait out every verdict, then let the pipe empty
    task automatic settle_block();
        pix.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Pixel and window generators
    // ------------------------------------------------------------------------
    function automatic pixel_t pixel_at(logic op, int unsigned x, int unsigned y,
                                        int unsigned r, int unsigned g, int unsigned b,
                                        logic last);
        pixel_t p;
        p.op    = op;
        p.x     = COORD_W'(x);
        p.y     = COORD_W'(y);
        p.red   = CHAN_W'(r);
        p.green = CHAN_W'(g);
        p.blue  = CHAN_W'(b);
        p.last  = last;
        return p;
    endfunction

    function automatic pixel_t noise_pixel(logic op, logic last);
        return pixel_at(op, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                        $urandom_range(CHAN_MAX), $urandom_range(CHAN_MAX),
                        $urandom_range(CHAN_MAX), last);
    endfunction

    // Compare requests mostly repeat or nudge the captured color
    function automatic pixel_t spot_pixel(spot_t s, logic op, logic last);
        int chan [3];
        int roll, pick;
        chan[0] = int'(s.red);
        chan[1] = int'(s.green);
        chan[2] = int'(s.blue);
        if (op == OP_COMPARE)
        begin
            roll = int'($urandom_range(9));
            if (roll >= 4 && roll < 8)
            begin
                pick = int'($urandom_range(2));
                chan[pick] = chan[pick] + int'($urandom_range(40)) - 20;
                if (chan[pick] < 0)
                    chan[pick] = 0;
                if (chan[pick] > int'(CHAN_MAX))
                    chan[pick] = int'(CHAN_MAX);
            end
            else if (roll >= 8)
            begin
                foreach (chan[i])
                    chan[i] = int'($urandom_range(CHAN_MAX));
            end
        end
        return pixel_at(op, 32'(s.x), 32'(s.y), 32'(chan[0]), 32'(chan[1]), 32'(chan[2]),
                        last);
    endfunction

    function automatic int unsigned pick_tolerance();
        case ($urandom_range(3))
            0: return 0;
            1: return INTENSITY_MAX;
            2: return $urandom_range(30);
            default: return $urandom_range(INTENSITY_MAX);
        endcase
    endfunction

    function automatic window_t pick_window();
        window_t     w;
        int unsigned kind, wd, ht;
        kind = $urandom_range(15);
        if (kind == 0)
        begin
            // Degenerate: nothing can be sampled
            w.left   = $urandom_range(1, COORD_MAX);
            w.right  = $urandom_range(w.left);
            w.top    = $urandom_range(COORD_MAX);
            w.bottom = $urandom_range(COORD_MAX);
        end
        else if (kind == 1)
        begin
            // Full width: rows past the first run beyond the store, but for row two's first pixel
            w.left   = 0;
            w.right  = COORD_MAX;
            w.top    = $urandom_range(COORD_MAX - 1);
            w.bottom = $urandom_range(w.top + 1, COORD_MAX);
        end
        else
        begin
            wd = $urandom_range(1, 12);
            ht = $urandom_range(1, 6);
            if (kind == 2)
            begin
                w.left = COORD_MAX - wd;
                w.top  = COORD_MAX - ht;
            end
            else
            begin
                w.left = $urandom_range(COORD_MAX - wd);
                w.top  = $urandom_range(COORD_MAX - ht);
            end
            w.right  = w.left + wd;
            w.bottom = w.top + ht;
        end
        w.tol_below = pick_tolerance();
        w.tol_above = pick_tolerance();
        case ($urandom_range(3))
            0: w.percent = 0;
            1: w.percent = PCT_MAX;
            2: w.percent = $urandom_range(1, 100);
            default: w.percent = $urandom_range(PCT_MAX);
        endcase
        w.color = $urandom_range(1);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // One window: program it, capture a reference, then compare frames
    // ------------------------------------------------------------------------
    task automatic run_window();
        window_t     w;
        spot_t       s;
        pixel_t      p;
        int unsigned wd, ht, n, roll, pick;
        logic        last;
        w = pick_window();
        settle_block();
        program_window(w);

        // Collect the spots of this window
        spots.delete();
        wd = w.right > w.left ? w.right - w.left : 0;
        ht = w.bottom > w.top ? w.bottom - w.top : 0;
        if (wd * ht > 0 && wd * ht <= 72)
        begin
            for (int unsigned yy = w.top; yy < w.bottom; yy++)
                for (int unsigned xx = w.left; xx < w.right; xx++)
                begin
                    s = {xx[COORD_W-1:0], yy[COORD_W-1:0], 8'($urandom_range(CHAN_MAX)),
                         8'($urandom_range(CHAN_MAX)), 8'($urandom_range(CHAN_MAX))};
                    spots.push_back(s);
                end
        end
        else if (wd * ht > 0)
        begin
            repeat (16)
            begin
                s.x     = COORD_W'(w.left + $urandom_range(wd - 1));
                s.y     = COORD_W'($urandom_range(3) == 0 ? w.top + $urandom_range(ht - 1)
                                                           : w.top);
                s.red   = CHAN_W'($urandom_range(CHAN_MAX));
                s.green = CHAN_W'($urandom_range(CHAN_MAX));
                s.blue  = CHAN_W'($urandom_range(CHAN_MAX));
                spots.push_back(s);
            end
        end

        // Capture frame, sprinkled with stray requests
        foreach (spots[i])
        begin
            if ($urandom_range(99) < 10)
                send_pixel(noise_pixel(1'($urandom_range(1)), 1'b0));
            send_pixel(spot_pixel(spots[i], OP_CAPTURE, i == spots.size() - 1));
        end
        if (spots.size() == 0)
            send_pixel(noise_pixel(OP_CAPTURE, 1'b1));

        // Compare frames; a few end on a capture or a stray request
        repeat ($urandom_range(2, 6))
        begin
            n = spots.size() * 2 + 2;
            n = $urandom_range(1, n > 40 ? 40 : n);
            for (int unsigned k = 0; k < n; k++)
            begin
                last = k == n - 1;
                roll = $urandom_range(99);
                if (spots.size() == 0 || roll < 8)
                    p = noise_pixel(1'($urandom_range(1)), last);
                else if (roll < 14)
                begin
                    pick = $urandom_range(spots.size() - 1);
                    spots[pick].red   = CHAN_W'($urandom_range(CHAN_MAX));
                    spots[pick].green = CHAN_W'($urandom_range(CHAN_MAX));
                    spots[pick].blue  = CHAN_W'($urandom_range(CHAN_MAX));
                    p = spot_pixel(spots[pick], OP_CAPTURE, last);
                end
                else
                    p = spot_pixel(spots[$urandom_range(spots.size() - 1)], OP_COMPARE, last);
                send_pixel(p);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned directed_items;
        rst_n           = 1'b0;
        calm            = 1'b0;
        pix.valid       = 1'b0;
        pix.operation   = OP_CAPTURE;
        pix.pixel_x     = '0;
        pix.pixel_y     = '0;
        pix.pixel_red   = '0;
        pix.pixel_green = '0;
        pix.pixel_blue  = '0;
        pix.frame_end   = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_LEFT;
        cfg.data        = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Small color window, exact match, no changes allowed
        settle_block();
        program_window('{left: 0, top: 0, right: 4, bottom: 2, tol_below: 0, tol_above: 0,
                         percent: 0, color: 1});
        send_pixel(pixel_at(OP_CAPTURE, 0, 0, 255, 255, 255, 1'b0));
        send_pixel(pixel_at(OP_CAPTURE, 1, 0, 0, 0, 0, 1'b0));
        send_pixel(pixel_at(OP_CAPTURE, 4095, 4095, 255, 0, 255, 1'b0));
        // Frame end on a capture clears the counts without a verdict
        send_pixel(pixel_at(OP_CAPTURE, 3, 1, 85, 170, 85, 1'b1));
        send_pixel(pixel_at(OP_COMPARE, 0, 0, 255, 255, 255, 1'b0));
        send_pixel(pixel_at(OP_COMPARE, 1, 0, 1, 0, 0, 1'b0));
        send_pixel(pixel_at(OP_COMPARE, 4095, 0, 0, 255, 0, 1'b0));
        send_pixel(pixel_at(OP_COMPARE, 3, 1, 85, 170, 85, 1'b1));
        // Empty region: only a pixel outside the window
        send_pixel(pixel_at(OP_COMPARE, 2048, 2048, 0, 0, 0, 1'b1));
        // Mixed operations in one frame
        send_pixel(pixel_at(OP_CAPTURE, 2, 1, 10, 20, 30, 1'b0));
        send_pixel(pixel_at(OP_COMPARE, 2, 1, 10, 20, 31, 1'b0));
        send_pixel(pixel_at(OP_COMPARE, 0, 0, 255, 255, 255, 1'b1));

        // Full-frame gray window: second row lies beyond the store but for its first pixel
        settle_block();
        program_window('{left: 0, top: 0, right: 4095, bottom: 4095, tol_below: 765,
                         tol_above: 0, percent: 255, color: 0});
        send_pixel(pixel_at(OP_CAPTURE, 4094, 0, 254, 0, 0, 1'b0));
        send_pixel(pixel_at(OP_CAPTURE, 1, 1, 255, 255, 255, 1'b0));
        send_pixel(pixel_at(OP_COMPARE, 4094, 0, 0, 255, 255, 1'b0));
        send_pixel(pixel_at(OP_COMPARE, 4094, 0, 255, 0, 0, 1'b0));
        send_pixel(pixel_at(OP_COMPARE, 1, 1, 0, 0, 0, 1'b1));

        // Degenerate rectangle samples nothing
        settle_block();
        program_window('{left: 100, top: 0, right: 100, bottom: 4095, tol_below: 0,
                         tol_above: 765, percent: 1, color: 1});
        send_pixel(pixel_at(OP_COMPARE, 100, 5, 9, 9, 9, 1'b1));

        // Single corner pixel, percent right on the boundary
        settle_block();
        program_window('{left: 4094, top: 4094, right: 4095, bottom: 4095, tol_below: 3,
                         tol_above: 3, percent: 50, color: 1});
        send_pixel(pixel_at(OP_CAPTURE, 4094, 4094, 100, 100, 100, 1'b1));
        send_pixel(pixel_at(OP_COMPARE, 4094, 4094, 101, 100, 100, 1'b0));
        send_pixel(pixel_at(OP_COMPARE, 4094, 4094, 104, 100, 100, 1'b1));
        directed_items = accepted_items;

        // Random windows until enough requests went through
        while (accepted_items < directed_items + RANDOM_ITEMS)
            run_window();

        settle_block();
        $display("Ran %0d pixel requests through %0d window settings.",
                 accepted_items, window_count);
        $display("Checked %0d verdicts: %0d on empty regions, %0d judged changed.",
                 board.verdicts_checked, board.empty_seen, board.moved_seen);
        if (board.errors == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("%0t: timeout, %0d verdicts still due", $time, board.pending());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
